### rtl/core/tga_rle_pixel_decoder_assert.svh
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TRD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/tga_rle_pkg.sv
package tga_rle_pkg;

   localparam int unsigned MAX_PACKET_PIXELS = 128;
   localparam logic [2:0]  MAX_PIXEL_BYTES   = 3'd4;

   localparam logic [7:0] RUN_FLAG   = 8'h80;
   localparam logic [6:0] COUNT_MASK = 7'h7f;

   localparam logic [1:0] CSR_COMPRESSED_MODE = 2'd0;
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH     = 2'd2;
   localparam logic [1:0] CSR_IMAGE_HEIGHT    = 2'd3;

   localparam logic [2:0] BPP_RESET = 3'd3;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_RAW    = 2'd1,
      PH_RUN    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic [31:0] first_index;
      logic        image_done;
      logic        overflow_error;
   } rsp_type;

endpackage

### rtl/core/tga_rle_pixel_decoder.sv
// result: a byte that completes a pixel or run has its result registered into the result queue
// throughput: one byte per cycle; a two-entry result queue keeps intake going while one
// result waits, and req_stall rises only when both entries are held
// reset: synchronous, active high; registers return to compressed mode, three bytes per
// pixel, empty image, header expected, result queue empty
module tga_rle_pixel_decoder import tga_rle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

`include "tga_rle_pixel_decoder_assert.svh"

   logic        mode_ff;
   logic [2:0]  bpp_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic [31:0] total_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  rem_ff, rem_in;
   logic [1:0]  pos_ff, pos_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] wr_ff, wr_in;
   logic        stop_ff, stop_in;

   rsp_type     head_ff, tail_ff, res_in;
   logic        head_v_ff, tail_v_ff;
   logic        push, pop, accept;

   phase_type   cur_phase;
   logic [7:0]  cur_rem, rem_dec;
   logic [1:0]  cur_pos;
   logic [31:0] cur_asm, cur_wr, asm_or, left;
   logic        cur_stop, at_end, last_byte, done_one;
   logic [2:0]  eff_bpp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = tail_v_ff;
   assign rsp_valid = head_v_ff;
   assign rsp_data  = head_ff;
   assign pop       = head_v_ff && !rsp_stall;

   // configuration and pixel count
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b1;
         bpp_ff    <= BPP_RESET;
         width_ff  <= '0;
         height_ff <= '0;
         total_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COMPRESSED_MODE: mode_ff <= csr_wdata[0];
            CSR_BYTES_PER_PIXEL: bpp_ff  <= csr_wdata[2:0];
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata;
               total_ff <= {16'b0, csr_wdata} * {16'b0, height_ff};
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata;
               total_ff  <= {16'b0, width_ff} * {16'b0, csr_wdata};
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (bpp_ff)
         3'd0:                   eff_bpp = 3'd1;
         3'd1, 3'd2, 3'd3, 3'd4: eff_bpp = bpp_ff;
         default:                eff_bpp = MAX_PIXEL_BYTES;
      endcase
   end

   // decode of one byte
   always_comb begin
      if (req_data.frame_start) begin
         cur_phase = PH_HEADER;
         cur_rem   = '0;
         cur_pos   = '0;
         cur_asm   = '0;
         cur_wr    = '0;
         cur_stop  = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_rem   = rem_ff;
         cur_pos   = pos_ff;
         cur_asm   = asm_ff;
         cur_wr    = wr_ff;
         cur_stop  = stop_ff;
      end

      phase_in  = cur_phase;
      rem_in    = cur_rem;
      pos_in    = cur_pos;
      asm_in    = cur_asm;
      wr_in     = cur_wr;
      stop_in   = cur_stop;
      push      = 1'b0;
      res_in    = '0;

      at_end    = cur_wr >= total_ff;
      done_one  = (cur_wr + 32'd1) == total_ff;
      left      = total_ff - cur_wr;
      asm_or    = cur_asm | ({24'b0, req_data.data_byte} << {cur_pos, 3'b000});
      last_byte = ({1'b0, cur_pos} + 3'd1) >= eff_bpp;
      rem_dec   = (cur_rem != 8'd0) ? cur_rem - 8'd1 : 8'd0;

      res_in.pixel_value = asm_or;
      res_in.first_index = cur_wr;

      if (!accept || cur_stop) begin
      end else if ((!mode_ff || cur_phase == PH_HEADER) && at_end) begin
         stop_in = 1'b1;
      end else if (mode_ff && cur_phase == PH_HEADER) begin
         if ((req_data.data_byte & RUN_FLAG) == 8'd0) begin
            phase_in = PH_RAW;
         end else begin
            phase_in = PH_RUN;
         end
         rem_in = {1'b0, req_data.data_byte[6:0] & COUNT_MASK} + 8'd1;
         pos_in = '0;
         asm_in = '0;
      end else if (!last_byte) begin
         asm_in = asm_or;
         pos_in = cur_pos + 2'd1;
      end else begin
         asm_in = '0;
         pos_in = '0;
         push   = 1'b1;
         if (!mode_ff) begin
            res_in.repeat_count = 8'd1;
            res_in.image_done   = done_one;
            wr_in               = cur_wr + 32'd1;
            stop_in             = done_one;
         end else if (cur_phase == PH_RAW) begin
            if (at_end) begin
               res_in.overflow_error = 1'b1;
               stop_in               = 1'b1;
            end else begin
               res_in.repeat_count = 8'd1;
               res_in.image_done   = done_one;
               wr_in               = cur_wr + 32'd1;
               rem_in              = rem_dec;
               if (rem_dec == 8'd0) begin
                  phase_in = PH_HEADER;
                  stop_in  = done_one;
               end
            end
         end else begin
            phase_in = PH_HEADER;
            rem_in   = '0;
            if ({24'b0, cur_rem} > left) begin
               res_in.repeat_count   = left[7:0];
               res_in.image_done     = left != 32'd0;
               res_in.overflow_error = 1'b1;
               wr_in                 = total_ff;
               stop_in               = 1'b1;
            end else begin
               res_in.repeat_count = cur_rem;
               res_in.image_done   = {24'b0, cur_rem} == left;
               wr_in               = cur_wr + {24'b0, cur_rem};
               stop_in             = (cur_wr + {24'b0, cur_rem}) >= total_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         rem_ff   <= '0;
         pos_ff   <= '0;
         asm_ff   <= '0;
         wr_ff    <= '0;
         stop_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         pos_ff   <= pos_in;
         asm_ff   <= asm_in;
         wr_ff    <= wr_in;
         stop_ff  <= stop_in;
      end
   end

   // two-entry result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         tail_v_ff <= 1'b0;
      end else if (pop) begin
         head_v_ff <= tail_v_ff || push;
         tail_v_ff <= tail_v_ff && push;
      end else if (push) begin
         head_v_ff <= 1'b1;
         tail_v_ff <= head_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (tail_v_ff) begin
            head_ff <= tail_ff;
            if (push) begin
               tail_ff <= res_in;
            end
         end else if (push) begin
            head_ff <= res_in;
         end
      end else if (push) begin
         if (head_v_ff) begin
            tail_ff <= res_in;
         end else begin
            head_ff <= res_in;
         end
      end
   end

   `TRD_ASSERT_NOW(a_queue_order, tail_v_ff, head_v_ff, "second result beat held without first")
   `TRD_ASSERT_NOW(a_stopped_silent, accept && stop_ff && !req_data.frame_start, !push,
      "result beat produced while decoder stopped")
   `TRD_ASSERT_NEXT(a_error_stops, push && res_in.overflow_error, stop_ff,
      "overflow did not stop the decoder")
   `TRD_ASSERT_NOW(a_packet_bound, 1'b1, rem_ff <= 8'(MAX_PACKET_PIXELS),
      "packet pixel count out of range")

endmodule
